// ===== rtl/gregorian_date_arithmetic_top_assert.svh =====
// Assertion macros shared by the date arithmetic RTL.
// Every macro expects a clock named clk and an active-low reset named arst_n.
`ifndef GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gda_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and calendar helper functions for the
// Gregorian date arithmetic block. Depends on nothing.
package gda_pkg;

	localparam int unsigned MAX_YEAR    = 9999;
	localparam int unsigned OFFSET_BITS = 17;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int SER_W  = 22;
	localparam int ORD_W  = 2;

	// Running day count of the month walk, wide enough for day + offset.
	localparam int WDAY_W = OFFSET_BITS + 2;

	// Division by 100 as a multiplication by a reciprocal, exact for 14-bit years.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam int QUO_W  = 8;
	localparam int PROD_W = YEAR_W + RECIP_W;

	// Intermediate serial width before the final truncation.
	localparam int SUM_W = SER_W + 1;

	localparam logic [YEAR_W-1:0] MAX_YEAR_V = YEAR_W'(MAX_YEAR);

	// Datapath operation codes.
	typedef logic [3:0] op_t;
	localparam op_t OP_IDLE        = 4'd0;
	localparam op_t OP_LOAD        = 4'd1;
	localparam op_t OP_DIV_YEAR    = 4'd2;
	localparam op_t OP_CHECK       = 4'd3;
	localparam op_t OP_DIV_SHIFTED = 4'd4;
	localparam op_t OP_SERIAL_A    = 4'd5;
	localparam op_t OP_SERIAL_B    = 4'd6;
	localparam op_t OP_COMPARE     = 4'd7;
	localparam op_t OP_WALK        = 4'd8;
	localparam op_t OP_PUBLISH     = 4'd9;

	// Order codes of the result.
	localparam logic [ORD_W-1:0] ORD_EARLIER = 2'd0;
	localparam logic [ORD_W-1:0] ORD_EQUAL   = 2'd1;
	localparam logic [ORD_W-1:0] ORD_LATER   = 2'd2;

	typedef struct packed {
		op_t  op;
		logic sel;   // 0: first date, 1: second date
	} gda_cmd_t;

	typedef struct packed {
		logic walk_done;
	} gda_stat_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		if (m == 4'd2) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

	// Days from March 1 to the start of the month, months counted from March.
	function automatic logic [8:0] march_days(input logic [MON_W-1:0] mm);
		logic [8:0] days;
		case (mm)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd31;
			4'd2:    days = 9'd61;
			4'd3:    days = 9'd92;
			4'd4:    days = 9'd122;
			4'd5:    days = 9'd153;
			4'd6:    days = 9'd184;
			4'd7:    days = 9'd214;
			4'd8:    days = 9'd245;
			4'd9:    days = 9'd275;
			4'd10:   days = 9'd306;
			4'd11:   days = 9'd337;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

// ===== rtl/gda_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the date arithmetic block: sequences the datapath steps
// and owns both handshakes. Depends on gda_pkg.
module gda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output gda_pkg::gda_cmd_t   cmd,
	input  gda_pkg::gda_stat_t  stat
);
	import gda_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIVY  = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_DIVS  = 4'd3;
	localparam logic [3:0] ST_SERA  = 4'd4;
	localparam logic [3:0] ST_SERB  = 4'd5;
	localparam logic [3:0] ST_CMP   = 4'd6;
	localparam logic [3:0] ST_WALK  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;
	logic       sel_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.sel = sel_q;
		case (state_q)
			ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_IDLE;
			ST_DIVY:  cmd.op = OP_DIV_YEAR;
			ST_CHECK: cmd.op = OP_CHECK;
			ST_DIVS:  cmd.op = OP_DIV_SHIFTED;
			ST_SERA:  cmd.op = OP_SERIAL_A;
			ST_SERB:  cmd.op = OP_SERIAL_B;
			ST_CMP:   cmd.op = OP_COMPARE;
			ST_WALK:  cmd.op = stat.walk_done ? OP_IDLE : OP_WALK;
			ST_DONE:  cmd.op = out_free ? OP_PUBLISH : OP_IDLE;
			default:  cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIVY;
						sel_q   <= 1'b0;
					end
				end
				ST_DIVY:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_DIVS;
				ST_DIVS:  state_q <= ST_SERA;
				ST_SERA:  state_q <= ST_SERB;
				ST_SERB: begin
					if (sel_q) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_DIVY;
						sel_q   <= 1'b1;
					end
				end
				ST_CMP: state_q <= ST_WALK;
				ST_WALK: begin
					if (stat.walk_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/gda_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the date arithmetic block: input capture, validity check,
// serial numbers, comparison, month walk and result registers. Depends on gda_pkg.
module gda_datapath (
	input  logic                                 clk,
	input  gda_pkg::gda_cmd_t                    cmd,
	output gda_pkg::gda_stat_t                   stat,
	input  logic [gda_pkg::DAY_W-1:0]            day_in,
	input  logic [gda_pkg::MON_W-1:0]            month_in,
	input  logic [gda_pkg::YEAR_W-1:0]           year_in,
	input  logic signed [gda_pkg::OFFSET_BITS-1:0] day_offset,
	input  logic [gda_pkg::DAY_W-1:0]            other_day,
	input  logic [gda_pkg::MON_W-1:0]            other_month,
	input  logic [gda_pkg::YEAR_W-1:0]           other_year,
	output logic [gda_pkg::DAY_W-1:0]            res_day,
	output logic [gda_pkg::MON_W-1:0]            res_month,
	output logic [gda_pkg::YEAR_W-1:0]           res_year,
	output logic                                 first_valid,
	output logic                                 second_valid,
	output logic                                 out_of_range,
	output logic [gda_pkg::SER_W-1:0]            first_serial,
	output logic [gda_pkg::SER_W-1:0]            second_serial,
	output logic [gda_pkg::SER_W-1:0]            distance,
	output logic [gda_pkg::ORD_W-1:0]            order
);
	import gda_pkg::*;

	// Captured request.
	logic [DAY_W-1:0]              d1_q, d2_q;
	logic [MON_W-1:0]              m1_q, m2_q;
	logic [YEAR_W-1:0]             y1_q, y2_q;
	logic signed [OFFSET_BITS-1:0] off_q;

	// Shared arithmetic registers.
	logic [QUO_W-1:0]  quo_q;
	logic [MON_W-1:0]  mm_q;
	logic [YEAR_W-1:0] yy_q;
	logic [SUM_W-1:0]  t_q;
	logic              v1_q, v2_q;
	logic [SER_W-1:0]  s1_q, s2_q;
	logic [SER_W-1:0]  dist_q;
	logic [ORD_W-1:0]  ord_q;

	// Month walk state.
	logic signed [WDAY_W-1:0] wday_q;
	logic [MON_W-1:0]         wmon_q;
	logic [YEAR_W-1:0]        wyear_q;
	logic [1:0]               ymod4_q;
	logic [6:0]               ymod100_q;
	logic [1:0]               cmod4_q;
	logic                     oor_q;

	// Operand of the selected date.
	logic [DAY_W-1:0]  cur_d;
	logic [MON_W-1:0]  cur_m;
	logic [YEAR_W-1:0] cur_y;

	assign cur_d = cmd.sel ? d2_q : d1_q;
	assign cur_m = cmd.sel ? m2_q : m1_q;
	assign cur_y = cmd.sel ? y2_q : y1_q;

	// Divide by 100 through the reciprocal.
	logic [YEAR_W-1:0] mul_in;
	logic [PROD_W-1:0] prod;
	logic [QUO_W-1:0]  quo;

	assign mul_in = (cmd.op == OP_DIV_YEAR) ? cur_y : yy_q;
	assign prod   = PROD_W'(mul_in) * PROD_W'(RECIP_100);
	assign quo    = prod[RECIP_SHIFT +: QUO_W];

	// Validity check of the selected date; quo_q holds year / 100 here.
	logic [YEAR_W-1:0] hund;
	logic [YEAR_W-1:0] rem_full;
	logic [6:0]        rem100;
	logic              leap_chk;
	logic [DAY_W-1:0]  mlen_chk;
	logic              valid_chk;
	logic [MON_W-1:0]  mm_chk;
	logic [YEAR_W-1:0] yy_chk;

	assign hund     = (YEAR_W'(quo_q) << 6) + (YEAR_W'(quo_q) << 5) + (YEAR_W'(quo_q) << 2);
	assign rem_full = cur_y - hund;
	assign rem100   = rem_full[6:0];
	assign leap_chk = (cur_y[1:0] == 2'd0) && ((rem100 != 7'd0) || (quo_q[1:0] == 2'd0));
	assign mlen_chk = month_len(cur_m, leap_chk);
	assign valid_chk = (cur_y != '0) && (cur_y <= MAX_YEAR_V)
		&& (cur_m >= 4'd1) && (cur_m <= 4'd12)
		&& (cur_d != '0) && (cur_d <= mlen_chk);
	assign mm_chk = (cur_m <= 4'd2) ? (cur_m + 4'd9) : (cur_m - 4'd3);
	assign yy_chk = cur_y - YEAR_W'(mm_chk >= 4'd10);

	// Serial number: 365*yy + yy/4 in the first step, the rest in the second.
	logic [SUM_W-1:0] t_sum;
	logic [SUM_W-1:0] ser_sum;
	logic             cur_v;

	assign t_sum = (SUM_W'(yy_q) << 8) + (SUM_W'(yy_q) << 6) + (SUM_W'(yy_q) << 5)
		+ (SUM_W'(yy_q) << 3) + (SUM_W'(yy_q) << 2) + SUM_W'(yy_q) + SUM_W'(yy_q >> 2);
	assign ser_sum = t_q - SUM_W'(quo_q) + SUM_W'(quo_q >> 2)
		+ SUM_W'(march_days(mm_q)) + SUM_W'(cur_d) - SUM_W'(1);
	assign cur_v = cmd.sel ? v2_q : v1_q;

	// Month walk step.
	logic                     leap_w;
	logic [DAY_W-1:0]         mlen_w;
	logic [DAY_W-1:0]         plen_w;
	logic signed [WDAY_W-1:0] mlen_s;
	logic signed [WDAY_W-1:0] plen_s;
	logic signed [WDAY_W-1:0] one_s;
	logic                     fwd;
	logic                     bwd;
	logic signed [WDAY_W-1:0] off_ext;
	logic signed [WDAY_W-1:0] d1_ext;

	assign leap_w  = (ymod4_q == 2'd0) && ((ymod100_q != 7'd0) || (cmod4_q == 2'd0));
	assign mlen_w  = month_len(wmon_q, leap_w);
	// The month before January is December of the previous year, always 31 days.
	assign plen_w  = (wmon_q <= 4'd1) ? 5'd31 : month_len(wmon_q - 4'd1, leap_w);
	assign mlen_s  = WDAY_W'(mlen_w);
	assign plen_s  = WDAY_W'(plen_w);
	assign one_s   = WDAY_W'(1);
	assign fwd     = wday_q > mlen_s;
	assign bwd     = wday_q < one_s;
	assign off_ext = WDAY_W'(off_q);
	assign d1_ext  = WDAY_W'(d1_q);

	assign stat.walk_done = !v1_q || oor_q || (!fwd && !bwd);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				d1_q  <= day_in;
				m1_q  <= month_in;
				y1_q  <= year_in;
				off_q <= day_offset;
				d2_q  <= other_day;
				m2_q  <= other_month;
				y2_q  <= other_year;
			end
			OP_DIV_YEAR, OP_DIV_SHIFTED: begin
				quo_q <= quo;
			end
			OP_CHECK: begin
				mm_q <= mm_chk;
				yy_q <= yy_chk;
				if (cmd.sel) begin
					v2_q <= valid_chk;
				end else begin
					v1_q      <= valid_chk;
					wday_q    <= d1_ext + off_ext;
					wmon_q    <= m1_q;
					wyear_q   <= y1_q;
					ymod4_q   <= y1_q[1:0];
					ymod100_q <= rem100;
					cmod4_q   <= quo_q[1:0];
					oor_q     <= 1'b0;
				end
			end
			OP_SERIAL_A: begin
				t_q <= t_sum;
			end
			OP_SERIAL_B: begin
				if (cmd.sel) begin
					s2_q <= cur_v ? ser_sum[SER_W-1:0] : '0;
				end else begin
					s1_q <= cur_v ? ser_sum[SER_W-1:0] : '0;
				end
			end
			OP_COMPARE: begin
				dist_q <= (s1_q > s2_q) ? (s1_q - s2_q) : (s2_q - s1_q);
				if (s1_q < s2_q) begin
					ord_q <= ORD_EARLIER;
				end else if (s1_q == s2_q) begin
					ord_q <= ORD_EQUAL;
				end else begin
					ord_q <= ORD_LATER;
				end
			end
			OP_WALK: begin
				if (fwd) begin
					if (wmon_q == 4'd12) begin
						if (wyear_q >= MAX_YEAR_V) begin
							// Ran past the last year: clamp to its last day.
							oor_q   <= 1'b1;
							wday_q  <= WDAY_W'(31);
							wmon_q  <= 4'd12;
							wyear_q <= MAX_YEAR_V;
						end else begin
							wday_q  <= wday_q - mlen_s;
							wmon_q  <= 4'd1;
							wyear_q <= wyear_q + YEAR_W'(1);
							ymod4_q <= ymod4_q + 2'd1;
							if (ymod100_q == 7'd99) begin
								ymod100_q <= 7'd0;
								cmod4_q   <= cmod4_q + 2'd1;
							end else begin
								ymod100_q <= ymod100_q + 7'd1;
							end
						end
					end else begin
						wday_q <= wday_q - mlen_s;
						wmon_q <= wmon_q + 4'd1;
					end
				end else if (bwd) begin
					if (wmon_q <= 4'd1) begin
						if (wyear_q <= YEAR_W'(1)) begin
							// Ran before year one: clamp to its first day.
							oor_q   <= 1'b1;
							wday_q  <= one_s;
							wmon_q  <= 4'd1;
							wyear_q <= YEAR_W'(1);
						end else begin
							wday_q  <= wday_q + plen_s;
							wmon_q  <= 4'd12;
							wyear_q <= wyear_q - YEAR_W'(1);
							ymod4_q <= ymod4_q - 2'd1;
							if (ymod100_q == 7'd0) begin
								ymod100_q <= 7'd99;
								cmod4_q   <= cmod4_q - 2'd1;
							end else begin
								ymod100_q <= ymod100_q - 7'd1;
							end
						end
					end else begin
						wday_q <= wday_q + plen_s;
						wmon_q <= wmon_q - 4'd1;
					end
				end
			end
			OP_PUBLISH: begin
				res_day       <= v1_q ? wday_q[DAY_W-1:0] : d1_q;
				res_month     <= v1_q ? wmon_q : m1_q;
				res_year      <= v1_q ? wyear_q : y1_q;
				first_valid   <= v1_q;
				second_valid  <= v2_q;
				out_of_range  <= v1_q && oor_q;
				first_serial  <= s1_q;
				second_serial <= s2_q;
				distance      <= dist_q;
				order         <= ord_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/gregorian_date_arithmetic_top.sv =====
`timescale 1ns / 1ps
// Gregorian date arithmetic: validity of two dates, offset addition on the
// first date, day serials, distance and order.
// Channels: one input request (both dates and a signed day offset) over
// in_valid/in_ready, one result over out_valid/out_ready.
// in_ready is high only while the block is idle; one request is worked at a time.
// The work is a fixed sequence of steps followed by the month walk, which steps
// one month per cycle until the offset is used up; the fixed part is two serial
// computations through one shared multiplier.
// The result sits in an output register; a new request is accepted while it
// waits, and the next result is held back until the receiver takes the first.
// A stalled receiver therefore stalls the block only at the end of the next request.
// Reset clears the controller and the output valid; no result is pending after it.
module gregorian_date_arithmetic_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [gda_pkg::DAY_W-1:0]              day_in,
	input  logic [gda_pkg::MON_W-1:0]              month_in,
	input  logic [gda_pkg::YEAR_W-1:0]             year_in,
	input  logic signed [gda_pkg::OFFSET_BITS-1:0] day_offset,
	input  logic [gda_pkg::DAY_W-1:0]              other_day,
	input  logic [gda_pkg::MON_W-1:0]              other_month,
	input  logic [gda_pkg::YEAR_W-1:0]             other_year,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [gda_pkg::DAY_W-1:0]              res_day,
	output logic [gda_pkg::MON_W-1:0]              res_month,
	output logic [gda_pkg::YEAR_W-1:0]             res_year,
	output logic                                   first_valid,
	output logic                                   second_valid,
	output logic                                   out_of_range,
	output logic [gda_pkg::SER_W-1:0]              first_serial,
	output logic [gda_pkg::SER_W-1:0]              second_serial,
	output logic [gda_pkg::SER_W-1:0]              distance,
	output logic [gda_pkg::ORD_W-1:0]              order
);
	import gda_pkg::*;

	`include "gregorian_date_arithmetic_top_assert.svh"

	gda_cmd_t  cmd;
	gda_stat_t stat;

	gda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	gda_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.stat          (stat),
		.day_in        (day_in),
		.month_in      (month_in),
		.year_in       (year_in),
		.day_offset    (day_offset),
		.other_day     (other_day),
		.other_month   (other_month),
		.other_year    (other_year),
		.res_day       (res_day),
		.res_month     (res_month),
		.res_year      (res_year),
		.first_valid   (first_valid),
		.second_valid  (second_valid),
		.out_of_range  (out_of_range),
		.first_serial  (first_serial),
		.second_serial (second_serial),
		.distance      (distance),
		.order         (order)
	);

	`GDA_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, cmd.op == OP_DIV_YEAR && !cmd.sel, "accepted request did not start the first division")
	`GDA_ASSERT_SAME(a_invalid_first, out_valid && !first_valid, !out_of_range && first_serial == '0, "invalid first date carries range flag or serial")
	`GDA_ASSERT_SAME(a_invalid_second, out_valid && !second_valid, second_serial == '0, "invalid second date carries a serial")
	`GDA_ASSERT_SAME(a_order_distance, out_valid, (order == ORD_EQUAL) == (distance == '0), "order and distance disagree")

endmodule
